@@ sv/rctg_pkg.sv @@
// Package with the shared widths, register indexes and constants of the radial texel generator.
package rctg_pkg;

	// Field widths of the coordinate and texel words.
	localparam int COL_W  = 10;
	localparam int ROW_W  = 10;
	localparam int OFF_W  = 21;
	localparam int BYTE_W = 8;

	// Register file.
	localparam int DIM_W     = 11;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CURVE_MODE   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_MODE   = 2'd3;
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd64;
	localparam logic CURVE_BORDER = 1'b0;

	localparam int unsigned MAX_DIM_DEF = 1024;

	// Fixed point: fractions are Q0.16 with one extra bit to hold 1.0.
	localparam int FRAC_W    = 16;
	localparam int V_W       = FRAC_W + 1;
	localparam logic [V_W-1:0] Q_ONE  = 17'h10000;
	localparam logic [V_W-1:0] Q_HALF = 17'h08000;
	localparam int DIV_STEPS = 4;

	// Square root: 18 root bits from a 36-bit radicand, three digits per stage.
	localparam int SQ_W       = 2 * V_W;
	localparam int ROOT_W     = 18;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int SREM_W     = ROOT_W + 2;
	localparam int SQRT_STEPS = 3;

	// Background profile: n = 5.0 - 4*s in Q.16, then n/3 by reciprocal.
	localparam int BG_W = 19;
	localparam logic [BG_W-1:0] BG_BASE = 19'd327680;
	localparam logic [ROOT_W-1:0] BG_ZERO_ROOT = 18'd81920;
	localparam int DIV3_W     = 20;
	localparam logic [DIV3_W-1:0] DIV3_MUL = 20'd699051;
	localparam int DIV3_SHIFT = 21;

endpackage

@@ sv/rctg_if.sv @@
// Handshake interfaces for the coordinate words and the texel words.
interface rctg_coord_if;
	logic                        valid;
	logic                        ready;
	logic [rctg_pkg::COL_W-1:0]  column;
	logic [rctg_pkg::ROW_W-1:0]  row;

	modport source(output valid, output column, output row, input ready);
	modport sink(input valid, input column, input row, output ready);
endinterface

interface rctg_texel_if;
	logic                        valid;
	logic                        ready;
	logic [rctg_pkg::OFF_W-1:0]  byte_offset;
	logic [rctg_pkg::BYTE_W-1:0] luminance;
	logic [rctg_pkg::BYTE_W-1:0] alpha_byte;
	logic                        two_bytes;

	modport source(output valid, output byte_offset, output luminance, output alpha_byte,
		output two_bytes, input ready);
	modport sink(input valid, input byte_offset, input luminance, input alpha_byte,
		input two_bytes, output ready);
endinterface

@@ sv/radial_curve_texel_generator_core.sv @@
// Top level of the radial curve texel generator: register file and fifteen-stage pipeline.
//
// Usage. Each word on the coord channel carries one texel coordinate (column, row); for each
// one the texel channel returns exactly one word with the texel's byte offset in the image
// buffer, its luminance and alpha bytes and a flag for two-byte texels. Both channels use a
// valid/ready handshake and a word moves at a clock edge where both are high.
// The APB port holds image width and height, the curve profile and the alpha mode. The user
// is to write it only while no word is in flight; the block itself does not enforce this.
// Reads return the stored values with no wait. Throughput is one word per clock while the
// receiver keeps ready high: the pipeline has fifteen register stages (input, four stages
// of a long divider producing four quotient bits each, squares, sum, six stages of a
// digit-by-digit square root producing three root bits each, curve shaping, and the output
// register), and every stage moves as soon as the stage after it has room.
// When the receiver stalls, the last stage holds its word and the stages behind it keep
// filling any empty slots, so coordinates are still taken until fifteen words are queued;
// nothing is lost or repeated. Reset clears every valid bit and restores width and height
// to 64 with border profile and one-byte texels.
module radial_curve_texel_generator_core #(
	parameter int unsigned MAX_DIM = rctg_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rctg_pkg::ADDR_W-1:0]   paddr,
	input  logic [rctg_pkg::DATA_W-1:0]   pwdata,
	output logic [rctg_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	rctg_coord_if.sink                    coord,
	rctg_texel_if.source                  texel
);

	// Largest dimension the 11-bit registers can reach after saturation.
	localparam int unsigned DimMax   = (1 << rctg_pkg::DIM_W) - 1;
	localparam int unsigned MaxDimClip = (MAX_DIM > DimMax) ? DimMax : MAX_DIM;
	localparam logic [rctg_pkg::DIM_W-1:0] MaxDimW = rctg_pkg::DIM_W'(MaxDimClip);
	// The divisor is dimension minus one, so it stays below MaxDimClip.
	localparam int DEN_W = (MaxDimClip > 2) ? $clog2(MaxDimClip) : 1;
	localparam int CMP_W = (DEN_W > rctg_pkg::COL_W) ? DEN_W : rctg_pkg::COL_W;
	localparam int NUM_STG = 15;

	typedef struct packed {
		logic [DEN_W-1:0]            den;
		logic [DEN_W-1:0]            rem;
		logic [rctg_pkg::FRAC_W-1:0] quo;
		logic                        zero;
		logic                        sat;
	} div_axis_t;

	typedef struct packed {
		div_axis_t                  x;
		div_axis_t                  y;
		logic [rctg_pkg::OFF_W-1:0] off;
	} div_word_t;

	typedef struct packed {
		logic [rctg_pkg::RAD_W-1:0]  rad;
		logic [rctg_pkg::SREM_W-1:0] rem;
		logic [rctg_pkg::ROOT_W-1:0] root;
		logic [rctg_pkg::OFF_W-1:0]  off;
	} sqrt_word_t;

	// Configuration registers.
	logic [rctg_pkg::DIM_W-1:0] image_width_q;
	logic [rctg_pkg::DIM_W-1:0] image_height_q;
	logic                       curve_mode_q;
	logic                       alpha_mode_q;

	// Pipeline control.
	logic [NUM_STG:1]   vld_s;
	logic [NUM_STG:1]   vld_in;
	logic [NUM_STG+1:1] adv;

	// Pipeline payload.
	div_word_t                  d_s1, d_s2, d_s3, d_s4, d_s5;
	logic [rctg_pkg::SQ_W-1:0]  sqx_s6, sqy_s6;
	logic [rctg_pkg::OFF_W-1:0] off_s6;
	sqrt_word_t                 r_s7, r_s8, r_s9, r_s10, r_s11, r_s12, r_s13;
	logic [rctg_pkg::V_W-1:0]   v_s14;
	logic [rctg_pkg::OFF_W-1:0] off_s14;
	logic [rctg_pkg::OFF_W-1:0] off_s15;
	logic [rctg_pkg::BYTE_W-1:0] lum_s15, alpha_s15;
	logic                       two_s15;

	// Combinational stage inputs.
	logic [rctg_pkg::DIM_W-1:0] w_sat, h_sat;
	logic [rctg_pkg::OFF_W-1:0] off_sum;
	div_word_t                  d_in;
	logic [rctg_pkg::V_W-1:0]   fx, fy;
	logic [rctg_pkg::SQ_W-1:0]  sqx, sqy;
	sqrt_word_t                 r_in;
	logic [rctg_pkg::V_W-1:0]   v_border, v_bg, v_in;
	logic [rctg_pkg::BG_W-1:0]  bg_n;
	logic [rctg_pkg::BG_W+rctg_pkg::DIV3_W-1:0] bg_prod;
	logic [rctg_pkg::V_W-1:0]   bg_q;
	logic [rctg_pkg::V_W+8-1:0] g_prod;
	logic [rctg_pkg::BYTE_W-1:0] g;

	logic [rctg_pkg::REG_IDX_W-1:0] reg_idx;

	// Register file. Writes complete in the access phase; pready is tied high.
	assign pready  = 1'b1;
	assign reg_idx = paddr[rctg_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= rctg_pkg::DIM_RESET;
			image_height_q <= rctg_pkg::DIM_RESET;
			curve_mode_q   <= rctg_pkg::CURVE_BORDER;
			alpha_mode_q   <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				rctg_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[rctg_pkg::DIM_W-1:0];
				end
				rctg_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= pwdata[rctg_pkg::DIM_W-1:0];
				end
				rctg_pkg::REG_CURVE_MODE: begin
					curve_mode_q <= pwdata[0];
				end
				rctg_pkg::REG_ALPHA_MODE: begin
					alpha_mode_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rctg_pkg::REG_IMAGE_WIDTH:  prdata = rctg_pkg::DATA_W'(image_width_q);
			rctg_pkg::REG_IMAGE_HEIGHT: prdata = rctg_pkg::DATA_W'(image_height_q);
			rctg_pkg::REG_CURVE_MODE:   prdata = rctg_pkg::DATA_W'(curve_mode_q);
			rctg_pkg::REG_ALPHA_MODE:   prdata = rctg_pkg::DATA_W'(alpha_mode_q);
			default:                    prdata = '0;
		endcase
	end

	// Dimension register values saturate on use to the range one to MAX_DIM (at most 2047).
	function automatic logic [rctg_pkg::DIM_W-1:0] sat_dim(input logic [rctg_pkg::DIM_W-1:0] d);
		logic [rctg_pkg::DIM_W-1:0] r;
		r = d;
		if (d == '0) begin
			r = rctg_pkg::DIM_W'(1);
		end else if (d > MaxDimW) begin
			r = MaxDimW;
		end
		return r;
	endfunction

	// Sets up one axis of the division coord * 2^16 / den. A coordinate at or past the
	// divisor gives a quotient of at least one, which saturates, so the remainder only
	// matters when the coordinate is below the divisor.
	function automatic div_axis_t div_setup(input logic [rctg_pkg::COL_W-1:0] c,
		input logic [rctg_pkg::DIM_W-1:0] dim);
		div_axis_t a;
		a.den  = DEN_W'(dim - rctg_pkg::DIM_W'(1));
		a.zero = (a.den == '0);
		a.sat  = (CMP_W'(c) >= CMP_W'(a.den));
		a.rem  = DEN_W'(c);
		a.quo  = '0;
		return a;
	endfunction

	// Four restoring division steps, one quotient bit each.
	function automatic div_axis_t div_steps(input div_axis_t a);
		div_axis_t        r;
		logic [DEN_W:0]   twice;
		r = a;
		for (int i = 0; i < rctg_pkg::DIV_STEPS; i++) begin
			twice = {r.rem, 1'b0};
			if (twice >= {1'b0, r.den}) begin
				r.rem = DEN_W'(twice - {1'b0, r.den});
				r.quo = {r.quo[rctg_pkg::FRAC_W-2:0], 1'b1};
			end else begin
				r.rem = twice[DEN_W-1:0];
				r.quo = {r.quo[rctg_pkg::FRAC_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic div_word_t div_word_steps(input div_word_t a);
		div_word_t r;
		r   = a;
		r.x = div_steps(a.x);
		r.y = div_steps(a.y);
		return r;
	endfunction

	function automatic logic [rctg_pkg::V_W-1:0] frac_of(input div_axis_t a);
		logic [rctg_pkg::V_W-1:0] f;
		if (a.zero) begin
			f = '0;
		end else if (a.sat) begin
			f = rctg_pkg::Q_ONE;
		end else begin
			f = {1'b0, a.quo};
		end
		return f;
	endfunction

	// Three digit-by-digit square root steps; each takes two radicand bits.
	function automatic sqrt_word_t sqrt_steps(input sqrt_word_t a);
		sqrt_word_t                  r;
		logic [rctg_pkg::SREM_W+1:0] cur;
		logic [rctg_pkg::SREM_W+1:0] trial;
		r = a;
		for (int i = 0; i < rctg_pkg::SQRT_STEPS; i++) begin
			cur   = {r.rem, r.rad[rctg_pkg::RAD_W-1 -: 2]};
			trial = {2'b00, r.root, 2'b01};
			if (cur >= trial) begin
				r.rem  = rctg_pkg::SREM_W'(cur - trial);
				r.root = {r.root[rctg_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				r.rem  = cur[rctg_pkg::SREM_W-1:0];
				r.root = {r.root[rctg_pkg::ROOT_W-2:0], 1'b0};
			end
			r.rad = {r.rad[rctg_pkg::RAD_W-3:0], 2'b00};
		end
		return r;
	endfunction

	// Stage 1 input: saturated dimensions, divider setup and the byte offset.
	always_comb begin
		w_sat   = sat_dim(image_width_q);
		h_sat   = sat_dim(image_height_q);
		off_sum = rctg_pkg::OFF_W'(rctg_pkg::OFF_W'(coord.row) * rctg_pkg::OFF_W'(w_sat))
			+ rctg_pkg::OFF_W'(coord.column);
		d_in.x  = div_setup(coord.column, w_sat);
		d_in.y  = div_setup(rctg_pkg::COL_W'(coord.row), h_sat);
		d_in.off = alpha_mode_q ? {off_sum[rctg_pkg::OFF_W-2:0], 1'b0} : off_sum;
	end

	// Stage 6 input: fractions and their squares.
	always_comb begin
		fx  = frac_of(d_s5.x);
		fy  = frac_of(d_s5.y);
		sqx = fx * fx;
		sqy = fy * fy;
	end

	// Stage 7 input: sum of squares loaded into the root unit.
	always_comb begin
		r_in.rad  = rctg_pkg::RAD_W'(sqx_s6) + rctg_pkg::RAD_W'(sqy_s6);
		r_in.rem  = '0;
		r_in.root = '0;
		r_in.off  = off_s6;
	end

	// Stage 14 input: curve shaping of the distance s.
	always_comb begin
		// Border ring: fold above one half, double, clamp at zero.
		if (r_s13.root <= rctg_pkg::ROOT_W'(rctg_pkg::Q_HALF)) begin
			v_border = rctg_pkg::V_W'({r_s13.root, 1'b0});
		end else if (r_s13.root >= rctg_pkg::ROOT_W'(rctg_pkg::Q_ONE)) begin
			v_border = '0;
		end else begin
			v_border = rctg_pkg::V_W'({rctg_pkg::ROOT_W'(rctg_pkg::Q_ONE) - r_s13.root, 1'b0});
		end

		// Background falloff: (5 - 4s) / 3, clamped to [0, 1].
		bg_n    = rctg_pkg::BG_BASE - rctg_pkg::BG_W'({r_s13.root, 2'b00});
		bg_prod = rctg_pkg::DIV3_MUL * bg_n;
		bg_q    = rctg_pkg::V_W'(bg_prod >> rctg_pkg::DIV3_SHIFT);
		if (r_s13.root >= rctg_pkg::BG_ZERO_ROOT) begin
			v_bg = '0;
		end else if (bg_prod[rctg_pkg::BG_W+rctg_pkg::DIV3_W-1:rctg_pkg::DIV3_SHIFT]
			> (rctg_pkg::BG_W+rctg_pkg::DIV3_W-rctg_pkg::DIV3_SHIFT)'(rctg_pkg::Q_ONE)) begin
			v_bg = rctg_pkg::Q_ONE;
		end else begin
			v_bg = bg_q;
		end

		v_in = (curve_mode_q == rctg_pkg::CURVE_BORDER) ? v_border : v_bg;
	end

	// Stage 15 input: the shaped value times 255, top byte kept.
	always_comb begin
		g_prod = {v_s14, 8'h00} - (rctg_pkg::V_W+8)'(v_s14);
		g      = g_prod[rctg_pkg::FRAC_W+7:rctg_pkg::FRAC_W];
	end

	// Each stage moves when it is empty or the stage after it moves.
	assign adv[NUM_STG+1] = texel.ready;
	for (genvar k = 1; k <= NUM_STG; k++) begin : g_adv
		assign adv[k] = !vld_s[k] || adv[k+1];
	end

	assign vld_in = {vld_s[NUM_STG-1:1], coord.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NUM_STG; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1])  d_s1  <= d_in;
		if (adv[2])  d_s2  <= div_word_steps(d_s1);
		if (adv[3])  d_s3  <= div_word_steps(d_s2);
		if (adv[4])  d_s4  <= div_word_steps(d_s3);
		if (adv[5])  d_s5  <= div_word_steps(d_s4);
		if (adv[6]) begin
			sqx_s6 <= sqx;
			sqy_s6 <= sqy;
			off_s6 <= d_s5.off;
		end
		if (adv[7])  r_s7  <= r_in;
		if (adv[8])  r_s8  <= sqrt_steps(r_s7);
		if (adv[9])  r_s9  <= sqrt_steps(r_s8);
		if (adv[10]) r_s10 <= sqrt_steps(r_s9);
		if (adv[11]) r_s11 <= sqrt_steps(r_s10);
		if (adv[12]) r_s12 <= sqrt_steps(r_s11);
		if (adv[13]) r_s13 <= sqrt_steps(r_s12);
		if (adv[14]) begin
			v_s14   <= v_in;
			off_s14 <= r_s13.off;
		end
		if (adv[15]) begin
			off_s15 <= off_s14;
			two_s15 <= alpha_mode_q;
			if (alpha_mode_q) begin
				lum_s15   <= '1;
				alpha_s15 <= g;
			end else begin
				lum_s15   <= g;
				alpha_s15 <= '0;
			end
		end
	end

	assign coord.ready       = adv[1];
	assign texel.valid       = vld_s[NUM_STG];
	assign texel.byte_offset = off_s15;
	assign texel.luminance   = lum_s15;
	assign texel.alpha_byte  = alpha_s15;
	assign texel.two_bytes   = two_s15;

endmodule

@@ tb/sv/radial_curve_texel_generator_core_test.sv @@
// Self-checking testbench of the radial curve texel generator core.
module radial_curve_texel_generator_core_test;
	import rctg_pkg::*;

	localparam int unsigned MAX_DIM = MAX_DIM_DEF;
	// Cycles with no word moving on any port before the run is declared hung.
	localparam int QUIET_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 250;
	localparam int REPORT_LIMIT  = 10;

	// One texel word as the block should deliver it.
	typedef struct packed {
		logic [OFF_W-1:0]  byte_offset;
		logic [BYTE_W-1:0] luminance;
		logic [BYTE_W-1:0] alpha_byte;
		logic              two_bytes;
	} texel_t;

	// One line of the directed stimulus. When set_cfg is high, the registers are
	// rewritten before the coordinate goes out. When typed is high, the expected
	// texel is the one written into the line rather than the predicted one.
	typedef struct {
		bit                set_cfg;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic              curve;
		logic              alpha;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		bit                typed;
		texel_t            want;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	rctg_coord_if coord_bus ();
	rctg_texel_if texel_bus ();

	radial_curve_texel_generator_core #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.coord  (coord_bus),
		.texel  (texel_bus)
	);

	// The testbench's own copy of the register file, kept in step with every write.
	logic [DIM_W-1:0] cfg_width  = DIM_RESET;
	logic [DIM_W-1:0] cfg_height = DIM_RESET;
	logic             cfg_curve  = CURVE_BORDER;
	logic             cfg_alpha  = 1'b0;

	// Texels predicted for accepted coordinates, oldest first.
	texel_t    pending_texels[$];
	stim_row_t directed_rows[$];

	int mismatches    = 0;
	int texels_seen   = 0;
	int words_sent    = 0;
	int settings_seen = 0;

	// Idling switches, flipped between phases so that some stretches run with no gaps.
	bit gaps_on   = 1'b0;
	bit stalls_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Width and height registers as the block uses them: zero counts as one and
	// anything above the maximum dimension saturates.
	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return d;
	endfunction

	// Coordinate over (dimension - 1) as a Q.16 fraction that saturates at 1.0.
	// A dimension of one has no span, so the fraction is zero.
	function automatic longint to_fraction(longint coord, int unsigned dim);
		longint q;
		if (dim == 1)
			return 0;
		q = (coord << 16) / longint'(dim - 1);
		return (q > longint'(Q_ONE)) ? longint'(Q_ONE) : q;
	endfunction

	// Predicts the texel word for one coordinate under the current registers.
	function automatic texel_t shade_texel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
		int unsigned w;
		int unsigned h;
		longint      fx;
		longint      fy;
		longint      sum;
		longint      root;
		longint      trial;
		longint      n;
		longint      v;
		longint      off;
		logic [BYTE_W-1:0] g;
		texel_t      t;

		w = clamp_dim(cfg_width);
		h = clamp_dim(cfg_height);
		fx = to_fraction(longint'(col), w);
		fy = to_fraction(longint'(row), h);

		// Integer square root of the Q2.32 sum, found one root bit at a time from the top.
		sum = fx * fx + fy * fy;
		root = 0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= sum)
				root = trial;
		end

		if (cfg_curve == CURVE_BORDER) begin
			// Ring profile: fold the far half back, then double and clamp to [0, 1].
			if (root > longint'(Q_HALF))
				root = longint'(Q_ONE) - root;
			v = 2 * root;
			if (v < 0)
				v = 0;
			if (v > longint'(Q_ONE))
				v = longint'(Q_ONE);
		end else begin
			// Falloff profile: three times 1 - (s - 0.5) / 0.75, divided by three.
			n = longint'(BG_BASE) - 4 * root;
			if (n <= 0) begin
				v = 0;
			end else begin
				v = n / 3;
				if (v > longint'(Q_ONE))
					v = longint'(Q_ONE);
			end
		end
		g = BYTE_W'((v * 255) >> 16);

		off = longint'(col) + longint'(row) * longint'(w);
		if (cfg_alpha)
			off = off << 1;
		t.byte_offset = off[OFF_W-1:0];
		if (cfg_alpha) begin
			t.luminance  = 8'hFF;
			t.alpha_byte = g;
			t.two_bytes  = 1'b1;
		end else begin
			t.luminance  = g;
			t.alpha_byte = '0;
			t.two_bytes  = 1'b0;
		end
		return t;
	endfunction

	// Gap length in cycles: mostly none, often short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch in %s: expected %0d, got %0d", what, want, got);
	endtask

	// All tasks below are entered in the time step of a rising clock edge and return in one.

	// Sends one coordinate word and, at the edge that takes it, files its expected texel.
	// A valid that stays high into the next word is never lowered in between.
	task automatic send_coord(logic [COL_W-1:0] col, logic [ROW_W-1:0] row, texel_t want);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			coord_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coord_bus.valid  <= 1'b1;
		coord_bus.column <= col;
		coord_bus.row    <= row;
		do @(posedge clk); while (!coord_bus.ready);
		pending_texels.push_back(want);
		words_sent++;
	endtask

	// Stops sending and waits until every expected texel has come back.
	task automatic drain();
		coord_bus.valid <= 1'b0;
		while (pending_texels.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// APB write of one register, followed by a read that must return the stored bits.
	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] got;
		bit                done;

		if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT)
			mask = (DATA_W'(1) << DIM_W) - 1;
		else
			mask = DATA_W'(1);

		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_IMAGE_WIDTH:  cfg_width  = data[DIM_W-1:0];
			REG_IMAGE_HEIGHT: cfg_height = data[DIM_W-1:0];
			REG_CURVE_MODE:   cfg_curve  = data[0];
			REG_ALPHA_MODE:   cfg_alpha  = data[0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);

		// Read back; prdata is taken in the middle of the access cycle.
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			got  = prdata;
			done = pready;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		// The bus stays idle before the next transfer starts.
		@(posedge clk);
		if (got !== (data & mask))
			report_mismatch($sformatf("read back of register %0d", idx), data & mask, got);
	endtask

	// Rewrites all four registers once the pipeline is empty. With noisy set, the bits
	// above each register's width carry junk that the block must drop.
	task automatic apply_settings(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic curve,
		logic alpha, bit noisy);
		logic [DATA_W-1:0] junk;
		drain();
		junk = noisy ? DATA_W'($urandom) : '0;
		reg_write(REG_IMAGE_WIDTH, {junk[DATA_W-1:DIM_W], w});
		junk = noisy ? DATA_W'($urandom) : '0;
		reg_write(REG_IMAGE_HEIGHT, {junk[DATA_W-1:DIM_W], h});
		junk = noisy ? DATA_W'($urandom) : '0;
		reg_write(REG_CURVE_MODE, {junk[DATA_W-1:1], curve});
		junk = noisy ? DATA_W'($urandom) : '0;
		reg_write(REG_ALPHA_MODE, {junk[DATA_W-1:1], alpha});
		settings_seen++;
	endtask

	task automatic add_row(bit set_cfg, int w, int h, bit curve, bit alpha, int c, int r,
		bit typed, int off, int lum, int alb, bit two);
		stim_row_t line;
		line.set_cfg = set_cfg;
		line.width   = DIM_W'(w);
		line.height  = DIM_W'(h);
		line.curve   = curve;
		line.alpha   = alpha;
		line.col     = COL_W'(c);
		line.row     = ROW_W'(r);
		line.typed   = typed;
		line.want    = '{OFF_W'(off), BYTE_W'(lum), BYTE_W'(alb), two};
		directed_rows.push_back(line);
	endtask

	// Texel side: every word taken is checked against the oldest prediction, and ready
	// is dropped at random while stalls are switched on.
	initial begin : texel_sink
		int     stall_left;
		texel_t got;
		texel_t want;

		stall_left = 0;
		texel_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (texel_bus.valid && texel_bus.ready) begin
				got = '{texel_bus.byte_offset, texel_bus.luminance, texel_bus.alpha_byte,
					texel_bus.two_bytes};
				texels_seen++;
				if (pending_texels.size() == 0) begin
					report_mismatch("texel word with nothing pending, byte_offset", -1,
						got.byte_offset);
				end else begin
					want = pending_texels.pop_front();
					if (got.byte_offset !== want.byte_offset)
						report_mismatch("byte_offset", want.byte_offset, got.byte_offset);
					if (got.luminance !== want.luminance)
						report_mismatch("luminance", want.luminance, got.luminance);
					if (got.alpha_byte !== want.alpha_byte)
						report_mismatch("alpha_byte", want.alpha_byte, got.alpha_byte);
					if (got.two_bytes !== want.two_bytes)
						report_mismatch("two_bytes", want.two_bytes, got.two_bytes);
				end
			end
			if (!stalls_on) begin
				stall_left = 0;
				texel_bus.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				texel_bus.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				texel_bus.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Watchdog: a run in which no word moves on any port for too long has hung.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((coord_bus.valid && coord_bus.ready) || (texel_bus.valid && texel_bus.ready)
				|| (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("radial_curve_texel_generator_core_test NOT OK");
		$finish;
	end

	// Main sequence: reset, directed lines, then random phases under changing registers.
	initial begin : stimulus
		stim_row_t        line;
		texel_t           want;
		int unsigned      wsat;
		int unsigned      hsat;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] sweep_col;
		logic [ROW_W-1:0] sweep_row;
		logic [DIM_W-1:0] dims [2];
		int               pick;

		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		coord_bus.valid  <= 1'b0;
		coord_bus.column <= '0;
		coord_bus.row    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines. The first ones run on the reset values of the registers.
		//      cfg  width height curve alpha col   row  typed offset   lum alpha two
		add_row(0,   0,    0,     0,    0,    0,    0,    1,   0,       0,  0,    0);
		add_row(0,   0,    0,     0,    0,    63,   0,    1,   63,      0,  0,    0);
		add_row(0,   0,    0,     0,    0,    0,    63,   1,   4032,    0,  0,    0);
		add_row(0,   0,    0,     0,    0,    1023, 1023, 1,   66495,   0,  0,    0);
		add_row(0,   0,    0,     0,    0,    31,   0,    0,   0,       0,  0,    0);
		add_row(0,   0,    0,     0,    0,    20,   30,   0,   0,       0,  0,    0);
		// Unit dimensions give zero fractions; zero dimensions behave as one.
		add_row(1,   1,    1,     0,    0,    5,    7,    1,   12,      0,  0,    0);
		add_row(0,   0,    0,     0,    0,    1023, 1023, 1,   2046,    0,  0,    0);
		add_row(1,   0,    0,     0,    0,    1023, 1023, 1,   2046,    0,  0,    0);
		add_row(1,   1,    1,     1,    0,    0,    0,    1,   0,       255, 0,   0);
		add_row(1,   1,    1,     1,    1,    3,    4,    1,   14,      255, 255, 1);
		// Dimensions above the maximum saturate; the far corner gives the largest offset.
		add_row(1,   2047, 2047,  1,    1,    1023, 1023, 1,   2097150, 255, 0,   1);
		add_row(0,   0,    0,     0,    0,    0,    0,    1,   0,       255, 255, 1);
		add_row(0,   0,    0,     0,    0,    512,  0,    0,   0,       0,  0,    0);
		add_row(1,   1024, 1024,  0,    1,    512,  0,    0,   0,       0,  0,    0);
		add_row(0,   0,    0,     0,    0,    1023, 0,    1,   2046,    255, 0,   1);
		add_row(0,   0,    0,     0,    0,    300,  400,  0,   0,       0,  0,    0);
		add_row(1,   1024, 1024,  1,    0,    300,  400,  0,   0,       0,  0,    0);
		add_row(0,   0,    0,     0,    0,    700,  700,  0,   0,       0,  0,    0);
		add_row(1,   2,    1023,  0,    0,    1,    0,    1,   1,       0,  0,    0);
		add_row(0,   0,    0,     0,    0,    0,    511,  0,   0,       0,  0,    0);
		add_row(1,   64,   64,    0,    0,    45,   45,   0,   0,       0,  0,    0);

		foreach (directed_rows[i]) begin
			line = directed_rows[i];
			if (line.set_cfg)
				apply_settings(line.width, line.height, line.curve, line.alpha, 1'b0);
			want = line.typed ? line.want : shade_texel(line.col, line.row);
			send_coord(line.col, line.row, want);
		end

		// Random phases. The first two pin the largest and the smallest images; the rest
		// draw dimensions that lean toward the interesting values.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int d = 0; d < 2; d++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					dims[d] = 0;
				else if (pick == 1)
					dims[d] = 1;
				else if (pick == 2)
					dims[d] = 2;
				else if (pick == 3)
					dims[d] = 1024;
				else if (pick == 4)
					dims[d] = DIM_W'($urandom_range(1025, 2047));
				else
					dims[d] = DIM_W'($urandom_range(3, 1024));
			end
			if (p == 0) begin
				dims[0] = 1024;
				dims[1] = 1024;
			end else if (p == 1) begin
				dims[0] = 1;
				dims[1] = 1;
			end
			gaps_on   = (p % 3 != 2);
			stalls_on = (p % 4 != 3);
			apply_settings(dims[0], dims[1], (p == 0) ? 1'b0 : ((p == 1) ? 1'b1 : 1'($urandom)),
				(p == 0) ? 1'b1 : ((p == 1) ? 1'b0 : 1'($urandom)), 1'b1);
			wsat = clamp_dim(cfg_width);
			hsat = clamp_dim(cfg_height);
			sweep_col = '0;
			sweep_row = '0;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Halfway through each phase the sender holds off until the pipeline is empty.
				if (k == PHASE_ITEMS / 2)
					drain();
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					// Raster walk over the image, as a texture fill would do it.
					col = sweep_col;
					row = sweep_row;
					if (sweep_col + 1 >= wsat) begin
						sweep_col = '0;
						sweep_row = (sweep_row + 1 >= hsat) ? '0 : sweep_row + 1'b1;
					end else begin
						sweep_col = sweep_col + 1'b1;
					end
				end else if (pick < 5) begin
					// Any coordinate at all, beyond the image too.
					col = COL_W'($urandom);
					row = ROW_W'($urandom);
				end else begin
					col = COL_W'($urandom_range(0, wsat - 1));
					row = ROW_W'($urandom_range(0, hsat - 1));
				end
				send_coord(col, row, shade_texel(col, row));
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (pending_texels.size() != 0)
			report_mismatch("texel words still pending at the end", 0, pending_texels.size());

		$display("%0d coordinate words sent, %0d texel words checked, %0d register settings.",
			words_sent, texels_seen, settings_seen);
		$display("Both curve profiles and texel sizes, unit, zero and saturated dimensions, and "
			, "coordinates past the image edge were exercised.");
		if (mismatches > REPORT_LIMIT)
			$display("%0d mismatches in total.", mismatches);
		if (mismatches == 0)
			$display("radial_curve_texel_generator_core_test OK");
		else
			$display("radial_curve_texel_generator_core_test NOT OK");
		$finish;
	end

endmodule
